FILE: design/sdaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_pkg: shared types and constants of the signed decimal ASCII formatter
// Format codes, ASCII codes, the BCD digit vector and the record handed from
// the bit-serial converter to the character sequencer.
// ----------------------------------------------------------------------------
package sdaf_pkg;

	// Field widths of the channels.
	localparam int VALUE_W = 16;
	localparam int CMD_W = 3;
	localparam int CHAR_W = 7;

	// Decimal digits needed for a 16-bit magnitude.
	localparam int NUM_DIGITS = 5;
	localparam int CNT_W = $clog2(VALUE_W);

	// Minutes in one hour, the divisor of the time form.
	localparam logic [6:0] MIN_PER_HOUR = 7'd60;

	// Format codes.
	localparam logic [CMD_W-1:0] FMT_PLAIN = 3'd0;
	localparam logic [CMD_W-1:0] FMT_DECI  = 3'd1;
	localparam logic [CMD_W-1:0] FMT_CENTI = 3'd2;
	localparam logic [CMD_W-1:0] FMT_MILLI = 3'd3;
	localparam logic [CMD_W-1:0] FMT_TWO   = 3'd4;
	localparam logic [CMD_W-1:0] FMT_TIME  = 3'd5;
	localparam logic [CMD_W-1:0] FMT_BOOL  = 3'd6;

	// ASCII characters used in the text.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_O     = 7'h6F;
	localparam logic [CHAR_W-1:0] CH_N     = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_F     = 7'h66;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	// Result of one conversion, as taken over by the character sequencer.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             neg;
		bcd_t             digits;
		logic [3:0]       min_tens;
		logic [3:0]       min_ones;
	} conv_res_t;

	// Splits a remainder below sixty into its two decimal digits.
	function automatic logic [7:0] min_to_bcd(input logic [5:0] r);
		logic [3:0] tens;
		logic [5:0] base;
		if (r >= 6'd50) begin
			tens = 4'd5;
			base = 6'd50;
		end else if (r >= 6'd40) begin
			tens = 4'd4;
			base = 6'd40;
		end else if (r >= 6'd30) begin
			tens = 4'd3;
			base = 6'd30;
		end else if (r >= 6'd20) begin
			tens = 4'd2;
			base = 6'd20;
		end else if (r >= 6'd10) begin
			tens = 4'd1;
			base = 6'd10;
		end else begin
			tens = 4'd0;
			base = 6'd0;
		end
		return {tens, 4'(r - base)};
	endfunction

endpackage
`default_nettype wire

FILE: design/sdaf_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_item_if: input channel of the formatter
// One beat carries a signed value and its format code.
// ----------------------------------------------------------------------------
interface sdaf_item_if;
	import sdaf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [CMD_W-1:0]          cmd;

	modport source (output valid, output value, output cmd, input ready);
	modport sink (input valid, input value, input cmd, output ready);
endinterface
`default_nettype wire

FILE: design/sdaf_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_char_if: character channel of the formatter
// One beat carries one ASCII character and the flag of the final character.
// ----------------------------------------------------------------------------
interface sdaf_char_if;
	import sdaf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

FILE: design/sdaf_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_conv: bit-serial converter
// Takes the magnitude of the value, divides it by sixty one bit per cycle for
// the time form of a non-negative value, then turns it into BCD by
// shift-and-add-three, one bit per cycle.
// ----------------------------------------------------------------------------
module sdaf_conv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sdaf_item_if.sink               item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output sdaf_pkg::conv_res_t     res
);
	import sdaf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_BCD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CMD_W-1:0]   cmd_q;
	logic               neg_q;
	logic [VALUE_W-1:0] sh_q;
	logic [5:0]         rem_q;
	bcd_t               bcd_q;

	logic [VALUE_W-1:0] raw;
	logic [VALUE_W-1:0] mag;
	logic               accept;
	logic [6:0]         trial;
	logic               ge;
	logic [5:0]         rem_next;
	bcd_t               adj;
	logic [4*NUM_DIGITS:0] dab_wide;

	// Magnitude of the incoming value as an unsigned 16-bit number.
	assign raw = $unsigned(item.value);
	assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;

	// One restoring division step by sixty.
	assign trial = {rem_q, sh_q[VALUE_W-1]};
	assign ge = (trial >= MIN_PER_HOUR);
	assign rem_next = ge ? 6'(trial - MIN_PER_HOUR) : trial[5:0];

	// Add three to every digit of five or more, then shift in the next bit.
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			adj[k] = (bcd_q[k] >= 4'd5) ? 4'(bcd_q[k] + 4'd3) : bcd_q[k];
		end
	end
	assign dab_wide = {adj, sh_q[VALUE_W-1]};

	// Sequencer of the two shift loops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (item.cmd == FMT_TIME && !raw[VALUE_W-1]) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_BCD;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_BCD;
					end
				end
				ST_BCD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= item.cmd;
					neg_q <= raw[VALUE_W-1];
					sh_q <= mag;
					rem_q <= '0;
					bcd_q <= '0;
				end
			end
			ST_DIV: begin
				sh_q <= {sh_q[VALUE_W-2:0], ge};
				rem_q <= rem_next;
			end
			ST_BCD: begin
				sh_q <= {sh_q[VALUE_W-2:0], 1'b0};
				bcd_q <= dab_wide[4*NUM_DIGITS-1:0];
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (state_q == ST_DONE);
	assign res.cmd = cmd_q;
	assign res.neg = neg_q;
	assign res.digits = bcd_q;
	assign {res.min_tens, res.min_ones} = min_to_bcd(rem_q);

	// Only the time form of a non-negative value goes through the divider.
	a_div_time_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (cmd_q == FMT_TIME && !neg_q))
		else $error("divider running for a form other than time");

	// The remainder of the division stays below sixty.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> rem_q < 6'd60)
		else $error("remainder out of range");

	// A finished conversion holds decimal digits only.
	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> (bcd_q[0] <= 4'd9 && bcd_q[1] <= 4'd9 &&
			bcd_q[2] <= 4'd9 && bcd_q[3] <= 4'd9 && bcd_q[4] <= 4'd9))
		else $error("BCD digit above nine");

endmodule
`default_nettype wire

FILE: design/sdaf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_emit: character sequencer
// Walks the digit positions of each number section from the top digit down,
// putting out the sign, the leading zero, the point, the digits and the section
// separator, or the bool letters, one beat at a time via an output register.
// ----------------------------------------------------------------------------
module sdaf_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	output logic                     res_ready,
	input  wire sdaf_pkg::conv_res_t res,
	sdaf_char_if.source              text
);
	import sdaf_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_ZERO  = 3'd2;
	localparam logic [2:0] PH_POINT = 3'd3;
	localparam logic [2:0] PH_DIGIT = 3'd4;
	localparam logic [2:0] PH_SEP   = 3'd5;
	localparam logic [2:0] PH_BOOL  = 3'd6;

	localparam logic [2:0] TOP_DIGIT = 3'(NUM_DIGITS - 1);

	logic [2:0]        ph_q;
	logic [2:0]        dig_q;
	logic              seg_q;
	logic              en_q;
	conv_res_t         r_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic              adv;
	logic              is_time;
	logic              final_seg;
	logic [CMD_W-1:0]  form;
	logic              sgn;
	bcd_t              min_bcd;
	bcd_t              seg_dig;
	logic [3:0]        cur;
	logic              point;
	logic              show;
	logic              nz;
	logic              emit;
	logic [CHAR_W-1:0] ch;
	logic              lst;
	logic [2:0]        ph_d;
	logic [2:0]        dig_d;
	logic              seg_d;
	logic              en_d;

	assign res_ready = (ph_q == PH_IDLE);
	assign adv = !out_valid_q || text.ready;

	// Parameters of the section being written.
	assign is_time = (r_q.cmd == FMT_TIME);
	assign final_seg = !is_time || seg_q;
	assign nz = |r_q.digits;
	assign min_bcd = {4'd0, 4'd0, 4'd0, r_q.min_tens, r_q.min_ones};

	always_comb begin
		if (is_time) begin
			form = FMT_TWO;
		end else if (r_q.cmd > FMT_TWO) begin
			form = FMT_PLAIN;
		end else begin
			form = r_q.cmd;
		end
	end

	always_comb begin
		if (!is_time) begin
			sgn = r_q.neg;
			seg_dig = r_q.digits;
		end else if (!seg_q) begin
			sgn = 1'b0;
			seg_dig = r_q.neg ? '0 : r_q.digits;
		end else begin
			sgn = r_q.neg;
			seg_dig = r_q.neg ? r_q.digits : min_bcd;
		end
	end

	assign cur = seg_dig[dig_q];
	assign point = (dig_q == 3'd2 && form == FMT_MILLI) ||
		(dig_q == 3'd1 && form == FMT_CENTI) ||
		(dig_q == 3'd0 && form == FMT_DECI);
	assign show = (cur != 4'd0) || en_q || (dig_q == 3'd0) ||
		(dig_q == 3'd1 && form == FMT_TWO);

	// Step decoder: what this position writes and where the walk goes next.
	always_comb begin
		emit = 1'b0;
		ch = CH_ZERO;
		lst = 1'b0;
		ph_d = ph_q;
		dig_d = dig_q;
		seg_d = seg_q;
		en_d = en_q;
		case (ph_q)
			PH_SIGN: begin
				emit = sgn;
				ch = CH_MINUS;
				ph_d = PH_ZERO;
				dig_d = TOP_DIGIT;
				en_d = 1'b0;
			end
			PH_ZERO: begin
				emit = point && !en_q;
				ch = CH_ZERO;
				ph_d = point ? PH_POINT : PH_DIGIT;
			end
			PH_POINT: begin
				emit = 1'b1;
				ch = CH_POINT;
				en_d = 1'b1;
				ph_d = PH_DIGIT;
			end
			PH_DIGIT: begin
				emit = show;
				ch = CH_ZERO + {3'b000, cur};
				en_d = en_q || show;
				lst = (dig_q == 3'd0) && final_seg;
				if (dig_q != 3'd0) begin
					dig_d = dig_q - 3'd1;
					ph_d = PH_ZERO;
				end else if (!final_seg) begin
					ph_d = PH_SEP;
				end else begin
					ph_d = PH_IDLE;
				end
			end
			PH_SEP: begin
				emit = 1'b1;
				ch = CH_POINT;
				seg_d = 1'b1;
				ph_d = PH_SIGN;
			end
			PH_BOOL: begin
				emit = 1'b1;
				if (dig_q == 3'd0) begin
					ch = CH_O;
				end else if (dig_q == 3'd1) begin
					ch = nz ? CH_N : CH_F;
					lst = nz;
				end else begin
					ch = CH_F;
					lst = 1'b1;
				end
				dig_d = dig_q + 3'd1;
				if (lst) begin
					ph_d = PH_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	// Walk state; a new section list is taken over when the walk is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			dig_q <= '0;
			seg_q <= 1'b0;
			en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ph_q == PH_IDLE) begin
				if (res_valid) begin
					ph_q <= (res.cmd == FMT_BOOL) ? PH_BOOL : PH_SIGN;
					dig_q <= '0;
					seg_q <= 1'b0;
					en_q <= 1'b0;
				end
			end else if (adv) begin
				ph_q <= ph_d;
				dig_q <= dig_d;
				seg_q <= seg_d;
				en_q <= en_d;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// Output register and the record of the item being written.
	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && res_valid) begin
			r_q <= res;
		end
		if (adv && emit) begin
			out_char_q <= ch;
			out_last_q <= lst;
		end
	end

	assign text.valid = out_valid_q;
	assign text.char_out = out_char_q;
	assign text.last = out_last_q;

	// The bool form writes at most three letters.
	a_bool_index: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_BOOL |-> dig_q <= 3'd2)
		else $error("bool letter index out of range");

	// The final character comes only from the units digit or the bool word.
	a_last_source: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit && lst) |=> (ph_q == PH_IDLE && text.valid && text.last))
		else $error("final character written from a wrong step");

endmodule
`default_nettype wire

FILE: design/signed_decimal_ascii_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter: signed 16-bit value to ASCII decimal text
// Each beat on the item channel carries a value and a format code; the text
// leaves on the character channel one character per beat, the final one
// flagged by last. Forms: plain, deci, centi, milli, two digits, time
// (hours.minutes) and bool (on / off).
//
// An item is taken when the converter is idle. The converter turns the
// magnitude into BCD by shift-and-add-three (the time form of a non-negative
// value first divides by sixty one bit per cycle), then hands the result over;
// it takes no new item before the last one has been handed over. The character
// sequencer walks every digit position, one step a cycle unless the receiver
// stalls, while the converter works on the next item; a finished item waits
// in the converter until the walk of the one before it is done.
// Reset clears both sequencers and drops any item in flight. While the
// receiver stalls, the character register holds and the walk waits.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sdaf_item_if.sink   item,
	sdaf_char_if.source text
);
	import sdaf_pkg::*;

	logic      res_valid;
	logic      res_ready;
	conv_res_t res;

	// Bit-serial conversion of the magnitude into decimal digits.
	sdaf_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Character walk over the digits.
	sdaf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.text      (text)
	);

endmodule
`default_nettype wire

FILE: test/signed_decimal_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_tb: self-checking bench of the formatter
// A short table of directed items covers the extremes, every format code and
// the awkward cases of the time form. Random items follow, first without
// gaps and then with gaps on both channels and one long receiver stall. Every
// character beat is checked against the text worked out at the item beat.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_tb;
	import sdaf_pkg::*;

	// Format code with no form of its own; it is printed as plain text.
	localparam logic [CMD_W-1:0] FMT_UNUSED = 3'd7;

	// A typed text of zero means the text is worked out by the predictor.
	localparam logic [71:0] BY_MODEL = '0;

	localparam int RANDOM_ITEMS = 285;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CMD_W-1:0]   cmd;
		logic [71:0]        text;
	} directed_row_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_beat_t;

	// Directed items; the text, where given, is right-aligned ASCII.
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{16'h0000, FMT_PLAIN, "0"},
		'{16'h7FFF, FMT_PLAIN, "32767"},
		'{16'h8000, FMT_PLAIN, "-32768"},
		'{16'hFFFF, FMT_PLAIN, "-1"},
		'{16'd5, FMT_DECI, "0.5"},
		'{16'd5, FMT_CENTI, "0.05"},
		'{16'd5, FMT_MILLI, "0.005"},
		'{16'h0000, FMT_DECI, "0.0"},
		'{16'h7FFF, FMT_DECI, "3276.7"},
		'{16'h8000, FMT_MILLI, "-32.768"},
		'{16'd123, FMT_CENTI, BY_MODEL},
		'{16'hFFD3, FMT_DECI, BY_MODEL},
		'{16'd1234, FMT_MILLI, BY_MODEL},
		'{16'h0000, FMT_TWO, "00"},
		'{16'd7, FMT_TWO, "07"},
		'{16'hFFFD, FMT_TWO, "-03"},
		'{16'h0000, FMT_TIME, "00.00"},
		'{16'd59, FMT_TIME, "00.59"},
		'{16'd60, FMT_TIME, BY_MODEL},
		'{16'h7FFF, FMT_TIME, "546.07"},
		'{16'hFFFB, FMT_TIME, "00.-05"},
		'{16'h8000, FMT_TIME, "00.-32768"},
		'{16'h0000, FMT_BOOL, "off"},
		'{16'h8000, FMT_BOOL, "on"},
		'{16'd1234, FMT_UNUSED, BY_MODEL}
	};

	logic clk;
	logic arst_n;

	sdaf_item_if item_ch ();
	sdaf_char_if text_ch ();

	signed_decimal_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.text   (text_ch)
	);

	logic [CHAR_W-1:0] line_chars[$];
	text_beat_t        expected_chars[$];
	logic [71:0]       typed_texts[$];
	int                mismatches = 0;
	int                idle_cycles = 0;
	bit                idle_on = 1'b0;
	bit                hold_request = 1'b0;

	// Random gap length; one gap in sixteen is drawn from a longer range.
	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(20, 60);
		end
		return $urandom_range(1, 3);
	endfunction

	// Appends the decimal text of a 16-bit two's complement number.
	function automatic void append_decimal(input logic [VALUE_W-1:0] raw,
			input logic [CMD_W-1:0] form);
		int mag;
		int d[5];
		bit shown;
		bit point;
		shown = 1'b0;
		mag = int'(raw);
		if (raw[VALUE_W-1]) begin
			mag = 65536 - mag;
			line_chars.push_back(CH_MINUS);
		end
		d[4] = mag / 10000;
		mag = mag % 10000;
		d[3] = mag / 1000;
		mag = mag % 1000;
		d[2] = mag / 100;
		mag = mag % 100;
		d[1] = mag / 10;
		d[0] = mag % 10;
		for (int i = 4; i >= 0; i--) begin
			point = (i == 2 && form == FMT_MILLI) || (i == 1 && form == FMT_CENTI) ||
				(i == 0 && form == FMT_DECI);
			// A point with nothing before it gets a leading zero.
			if (point) begin
				if (!shown) begin
					line_chars.push_back(CH_ZERO);
				end
				line_chars.push_back(CH_POINT);
				shown = 1'b1;
			end
			if (d[i] != 0 || shown || i == 0 || (i == 1 && form == FMT_TWO)) begin
				line_chars.push_back(CHAR_W'(CH_ZERO + d[i]));
				shown = 1'b1;
			end
		end
	endfunction

	// Works out the text of one item and queues its character beats.
	function automatic void predict_text(input logic [VALUE_W-1:0] raw,
			input logic [CMD_W-1:0] cmd, input logic [71:0] typed);
		line_chars.delete();
		if (typed != BY_MODEL) begin
			for (int i = 8; i >= 0; i--) begin
				if (typed[i*8 +: 8] != 8'h00) begin
					line_chars.push_back(typed[i*8 +: CHAR_W]);
				end
			end
		end else begin
			case (cmd)
				FMT_TIME: begin
					// Negative minutes keep a zero hours part.
					if (raw[VALUE_W-1]) begin
						append_decimal('0, FMT_TWO);
						line_chars.push_back(CH_POINT);
						append_decimal(raw, FMT_TWO);
					end else begin
						append_decimal(raw / MIN_PER_HOUR, FMT_TWO);
						line_chars.push_back(CH_POINT);
						append_decimal(raw % MIN_PER_HOUR, FMT_TWO);
					end
				end
				FMT_BOOL: begin
					line_chars.push_back(CH_O);
					if (raw != '0) begin
						line_chars.push_back(CH_N);
					end else begin
						line_chars.push_back(CH_F);
						line_chars.push_back(CH_F);
					end
				end
				FMT_UNUSED: begin
					append_decimal(raw, FMT_PLAIN);
				end
				default: begin
					append_decimal(raw, cmd);
				end
			endcase
		end
		foreach (line_chars[k]) begin
			expected_chars.push_back('{line_chars[k], k == line_chars.size() - 1});
		end
	endfunction

	function automatic void note_mismatch(input string what, input text_beat_t want,
			input text_beat_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s: expected char %h last %b, got char %h last %b", $realtime,
				what, want.ch, want.last, got.ch, got.last);
		end
	endfunction

	// Offers one item, after an optional gap, and waits for its beat.
	task automatic offer_item(input logic [VALUE_W-1:0] value, input logic [CMD_W-1:0] cmd,
			input logic [71:0] typed);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_texts.push_back(typed);
		item_ch.valid <= 1'b1;
		item_ch.value <= value;
		item_ch.cmd <= cmd;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Item beats are turned into expected text; character beats are checked.
	always @(posedge clk) begin
		text_beat_t got;
		bit busy;
		busy = 1'b0;
		if (arst_n === 1'b1 && item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
			predict_text(item_ch.value, item_ch.cmd, typed_texts.pop_front());
			busy = 1'b1;
		end
		if (arst_n === 1'b1 && text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
			got = '{text_ch.char_out, text_ch.last};
			if (expected_chars.size() == 0) begin
				note_mismatch("character beat with no text expected", '0, got);
			end else if (expected_chars[0] !== got) begin
				note_mismatch("character mismatch", expected_chars.pop_front(), got);
			end else begin
				void'(expected_chars.pop_front());
			end
			busy = 1'b1;
		end
		idle_cycles <= busy ? 0 : idle_cycles + 1;
	end

	// Watchdog on cycles without any beat.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("signed_decimal_ascii_formatter_tb failed");
		$finish;
	end

	// Receiver: random stalls, and one long hold-off on request.
	initial begin
		text_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				text_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				text_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
			text_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Reset, directed table, random items, drain.
	initial begin
		logic [VALUE_W-1:0] value;
		logic [CMD_W-1:0]   cmd;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.value <= '0;
		item_ch.cmd <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		foreach (DIRECTED_ROWS[r]) begin
			offer_item(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].text);
		end

		// Random part: a stretch without gaps, then gaps and a long stall.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = (n >= 80);
			if (n == 150) begin
				hold_request = 1'b1;
			end
			case ($urandom_range(0, 3))
				0: value = VALUE_W'($urandom);
				1: value = VALUE_W'($urandom_range(0, 2000) - 1000);
				2: value = VALUE_W'($urandom_range(0, 5999));
				default: begin
					case ($urandom_range(0, 2))
						0: value = 16'h8000;
						1: value = 16'h7FFF;
						default: value = 16'h0000;
					endcase
				end
			endcase
			cmd = CMD_W'($urandom_range(0, 7));
			offer_item(value, cmd, BY_MODEL);
		end
		item_ch.valid <= 1'b0;

		// Wait for every character, then keep watching for strays.
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("signed_decimal_ascii_formatter_tb passed");
		end else begin
			$display("signed_decimal_ascii_formatter_tb failed");
		end
		$finish;
	end

endmodule
